// File: rtl/core/line_resampler_box_triangle_assert.svh
// Assertion macros for the line resampler.
// Expects clk and arst_n in the scope of each use.
`ifndef LINE_RESAMPLER_BOX_TRIANGLE_ASSERT_SVH
`define LINE_RESAMPLER_BOX_TRIANGLE_ASSERT_SVH

// Condition holds in the same cycle
`define LRBT_ASSERT_IMPL(lbl, pre, post, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Condition holds in the following cycle
`define LRBT_ASSERT_NEXT(lbl, pre, post, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/core/lrbt_pkg.sv
// Shared types and constants of the line resampler.
// No dependencies; imported by the interfaces, divider, datapath, controller and top.
package lrbt_pkg;

	localparam int SAMPLE_W   = 16;             // sample width
	localparam int IDX_W      = 8;              // window index width
	localparam int CNT_W      = 7;              // output count width
	localparam int FRAC_W     = 16;             // fraction bits of Q formats
	localparam int RATIO_W    = 24;             // Q8.16 ratio and position
	localparam int REM_W      = 7;              // remainder of position step
	localparam int SPAN_W     = 10;             // tent tap count
	localparam int TOT_W      = 34;             // tent weight total
	localparam int DIST_W     = 28;             // signed tap distance
	localparam int TAPP_W     = 12;             // signed tap position
	localparam int WGT_W      = FRAC_W + 1;     // weight up to 1.0
	localparam int PROD_W     = SAMPLE_W + WGT_W + 1;
	localparam int ACC_W      = PROD_W + 2;
	localparam int DIV_STEP_W = 5;

	localparam int REG_ADDR_W = 2;
	localparam int REG_DATA_W = 8;

	// Register indexes
	localparam logic [REG_ADDR_W-1:0] REG_FILTER_MODE = 2'd0;
	localparam logic [REG_ADDR_W-1:0] REG_FIRST_INDEX = 2'd1;
	localparam logic [REG_ADDR_W-1:0] REG_LAST_INDEX  = 2'd2;
	localparam logic [REG_ADDR_W-1:0] REG_OUT_COUNT   = 2'd3;

	// Filter modes
	localparam logic FILTER_BOX      = 1'b0;
	localparam logic FILTER_TRIANGLE = 1'b1;

	typedef enum logic [1:0] {
		DIV_RATIO,
		DIV_SPAN,
		DIV_WEIGHT
	} div_sel_t;

	typedef enum logic [1:0] {
		RD_TAP0,
		RD_TAP1,
		RD_TENT
	} rd_src_t;

	typedef enum logic [1:0] {
		WT_TAP0,
		WT_TAP1,
		WT_DIV
	} wt_src_t;

	// Controller to datapath
	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_ratio;
		logic     take_span;
		logic     clear_acc;
		logic     rd_en;
		rd_src_t  rd_src;
		logic     mul;
		wt_src_t  wt_src;
		logic     acc;
		logic     tent_a;
		logic     tent_b;
		logic     p1_step;
		logic     p2_init;
		logic     tap_adv;
		logic     emit;
	} lrbt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic line_done;
		logic div_busy;
		logic tent;
		logic linear;
		logic w_pos;
		logic tap_last;
		logic total_zero;
		logic k_last;
		logic out_free;
	} lrbt_stat_t;

endpackage

// File: rtl/core/lrbt_in_if.sv
// Input channel of the line resampler: one line sample per request.
// Depends on lrbt_pkg.
interface lrbt_in_if import lrbt_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       line_end;

	modport source (output valid, output sample_in, output line_end, input ready);
	modport sink (input valid, input sample_in, input line_end, output ready);
endinterface

// File: rtl/core/lrbt_out_if.sv
// Output channel of the line resampler: one resampled value per request.
// Depends on lrbt_pkg.
interface lrbt_out_if import lrbt_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       out_last;

	modport source (output valid, output sample_out, output out_last, input ready);
	modport sink (input valid, input sample_out, input out_last, output ready);
endinterface

// File: rtl/core/lrbt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lrbt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/lrbt_div.sv
// Restoring divider, one quotient bit per cycle, with preloadable remainder.
// Depends on lrbt_pkg.
module lrbt_div
	import lrbt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [TOT_W-1:0]      rem_init,
	input  logic [RATIO_W-1:0]    dividend,
	input  logic [TOT_W-1:0]      divisor,
	input  logic [DIV_STEP_W-1:0] steps,
	output logic                  busy,
	output logic [RATIO_W-1:0]    quot,
	output logic [TOT_W-1:0]      rem
);

	logic                  busy_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic [TOT_W-1:0]      rem_q;
	logic [RATIO_W-1:0]    dvd_q;
	logic [RATIO_W-1:0]    quot_q;
	logic [TOT_W-1:0]      div_q;
	logic [TOT_W:0]        trial;
	logic                  ge;
	logic [TOT_W:0]        diff;

	// One trial subtraction
	assign trial = {rem_q, dvd_q[RATIO_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_STEP_W'(1);
			if (cnt_q == DIV_STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			dvd_q  <= dividend;
			div_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
			dvd_q  <= {dvd_q[RATIO_W-2:0], 1'b0};
			quot_q <= {quot_q[RATIO_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// File: rtl/core/lrbt_dp.sv
// Datapath of the line resampler: registers, line store, divider, MAC, output.
// Depends on lrbt_pkg, lrbt_in_if, lrbt_out_if, lrbt_ram, lrbt_div.
module lrbt_dp
	import lrbt_pkg::*;
#(
	parameter int LINE_DEPTH = 256,
	parameter int OUT_MAX    = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrbt_cmd_t             cmd,
	output lrbt_stat_t            st,
	input  logic                  cfg_we,
	input  logic [REG_ADDR_W-1:0] cfg_index,
	input  logic [REG_DATA_W-1:0] cfg_data,
	lrbt_in_if.sink               in_ch,
	lrbt_out_if.source            out_ch
);

	localparam int AW   = $clog2(LINE_DEPTH);
	localparam int LCW  = $clog2(LINE_DEPTH + 1);
	localparam int CW   = (AW > IDX_W) ? AW : IDX_W;
	localparam int VQ_W = ACC_W - FRAC_W;

	localparam logic signed [VQ_W-1:0] SAT_HI =
		{{(VQ_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [VQ_W-1:0] SAT_LO =
		{{(VQ_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [DIST_W-1:0] D_STEP =
		{{(DIST_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};
	localparam logic [WGT_W-1:0] WGT_ONE = {1'b1, {FRAC_W{1'b0}}};

	// Configuration registers
	logic             mode_q;
	logic [IDX_W-1:0] first_q;
	logic [IDX_W-1:0] last_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= FILTER_TRIANGLE;
			first_q <= IDX_W'(0);
			last_q  <= IDX_W'(1);
			count_q <= CNT_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_MODE: mode_q  <= cfg_data[0];
				REG_FIRST_INDEX: first_q <= cfg_data;
				REG_LAST_INDEX:  last_q  <= cfg_data;
				REG_OUT_COUNT:   count_q <= cfg_data[CNT_W-1:0];
				default:         mode_q  <= mode_q;
			endcase
		end
	end

	// Window geometry; the user must keep it stable while a line is computed (the block does not enforce this)
	logic [IDX_W-1:0] last_c;
	logic [IDX_W-1:0] diff;
	logic [CNT_W-1:0] n_c;
	logic [CNT_W-1:0] den;
	logic [IDX_W-1:0] den_x;
	logic             is_box;

	assign last_c = (last_q < first_q) ? first_q : last_q;
	assign diff   = last_c - first_q;
	assign n_c    = (count_q < CNT_W'(2)) ? CNT_W'(2) :
		(count_q > CNT_W'(OUT_MAX)) ? CNT_W'(OUT_MAX) : count_q;
	assign den    = n_c - CNT_W'(1);
	assign den_x  = {{(IDX_W-CNT_W){1'b0}}, den};
	assign is_box = (mode_q == FILTER_BOX);

	// Line loading
	logic           accept;
	logic [LCW-1:0] load_cnt_q;
	logic           room;

	assign in_ch.ready = cmd.load;
	assign accept      = in_ch.valid && cmd.load;
	assign room        = load_cnt_q < LCW'(LINE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
		end else if (accept) begin
			if (in_ch.line_end) begin
				load_cnt_q <= '0;
			end else if (room) begin
				load_cnt_q <= load_cnt_q + LCW'(1);
			end
		end
	end

	// Divider operand selection
	logic [TOT_W-1:0]      div_rem_init;
	logic [RATIO_W-1:0]    div_dividend;
	logic [TOT_W-1:0]      div_divisor;
	logic [DIV_STEP_W-1:0] div_steps;
	logic                  div_busy;
	logic [RATIO_W-1:0]    div_quot;
	logic [TOT_W-1:0]      div_rem;
	logic [SPAN_W-1:0]     span_num;
	logic [TOT_W-1:0]      total_q;
	logic [RATIO_W-1:0]    w_u;
	logic                  w_eq;

	assign span_num = {1'b0, diff, 1'b0} + SPAN_W'(den) - SPAN_W'(1);
	assign w_eq     = (TOT_W'(w_u) == total_q);

	always_comb begin
		div_rem_init = '0;
		div_dividend = '0;
		div_divisor  = TOT_W'(den);
		div_steps    = DIV_STEP_W'(RATIO_W);
		case (cmd.div_sel)
			DIV_RATIO: begin
				div_dividend = {diff, {FRAC_W{1'b0}}};
			end
			DIV_SPAN: begin
				div_dividend = RATIO_W'(span_num);
			end
			DIV_WEIGHT: begin
				div_rem_init = w_eq ? '0 : TOT_W'(w_u);
				div_divisor  = total_q;
				div_steps    = DIV_STEP_W'(FRAC_W);
			end
			default: begin
				div_dividend = '0;
			end
		endcase
	end

	lrbt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.rem_init (div_rem_init),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Per-line step values and output position
	logic [RATIO_W-1:0] ratio_q;
	logic [REM_W-1:0]   r0_q;
	logic [SPAN_W-1:0]  span_q;
	logic [CNT_W-1:0]   k_q;
	logic [RATIO_W-1:0] pos_q;
	logic [REM_W-1:0]   prem_q;
	logic [REM_W:0]     prem_sum;
	logic               prem_ge;
	logic [REM_W:0]     prem_sub;

	assign prem_sum = {1'b0, prem_q} + {1'b0, r0_q};
	assign prem_ge  = prem_sum >= {1'b0, den};
	assign prem_sub = prem_sum - {1'b0, den};

	always_ff @(posedge clk) begin
		if (cmd.take_ratio) begin
			ratio_q <= div_quot;
			r0_q    <= div_rem[REM_W-1:0];
		end
		if (cmd.take_span) begin
			span_q <= div_quot[SPAN_W-1:0];
			k_q    <= '0;
			pos_q  <= '0;
			prem_q <= '0;
		end else if (cmd.emit) begin
			k_q    <= k_q + CNT_W'(1);
			pos_q  <= pos_q + ratio_q + RATIO_W'(prem_ge);
			prem_q <= prem_ge ? prem_sub[REM_W-1:0] : prem_sum[REM_W-1:0];
		end
	end

	// Tent tap walk
	logic signed [RATIO_W:0]   t_q;
	logic signed [TAPP_W-1:0]  p_q;
	logic signed [TAPP_W-1:0]  p0_q;
	logic signed [DIST_W-1:0]  d_q;
	logic signed [DIST_W-1:0]  d0_q;
	logic [SPAN_W-1:0]         j_q;
	logic signed [DIST_W-1:0]  d_abs;
	logic signed [DIST_W-1:0]  w;
	logic                      w_pos;
	logic signed [TAPP_W-1:0]  p0_n;
	logic signed [DIST_W-1:0]  d0_n;

	assign d_abs = d_q[DIST_W-1] ? -d_q : d_q;
	assign w     = $signed({{(DIST_W-RATIO_W){1'b0}}, ratio_q}) - d_abs;
	assign w_pos = !w[DIST_W-1] && (w != '0);
	assign w_u   = w[RATIO_W-1:0];
	assign p0_n  = TAPP_W'(t_q >>> FRAC_W);
	assign d0_n  = $signed(DIST_W'(ratio_q) + DIST_W'(t_q[FRAC_W-1:0]));

	always_ff @(posedge clk) begin
		if (cmd.tent_a) begin
			t_q <= $signed({1'b0, pos_q}) - $signed({1'b0, ratio_q});
		end
		if (cmd.tent_b) begin
			p0_q    <= p0_n;
			d0_q    <= d0_n;
			p_q     <= p0_n;
			d_q     <= d0_n;
			j_q     <= '0;
			total_q <= '0;
		end else if (cmd.p2_init) begin
			p_q <= p0_q;
			d_q <= d0_q;
			j_q <= '0;
		end else if (cmd.tap_adv) begin
			p_q <= p_q + TAPP_W'(1);
			d_q <= d_q - D_STEP;
			j_q <= j_q + SPAN_W'(1);
			if (cmd.p1_step && w_pos) begin
				total_q <= total_q + TOT_W'(w_u);
			end
		end
	end

	// High quotient bit of a weight: tap weight equals the whole total
	logic qhigh_q;

	always_ff @(posedge clk) begin
		if (cmd.div_start && (cmd.div_sel == DIV_WEIGHT)) begin
			qhigh_q <= w_eq;
		end
	end

	// Read index selection and clamping
	logic [IDX_W-1:0]         left;
	logic [FRAC_W-1:0]        frac;
	logic [IDX_W:0]           right_n;
	logic [IDX_W-1:0]         right;
	logic signed [TAPP_W-1:0] tidx;
	logic signed [TAPP_W-1:0] first_s;
	logic signed [TAPP_W-1:0] last_s;
	logic [IDX_W-1:0]         tent_idx;
	logic [IDX_W-1:0]         rd_idx;
	logic [CW-1:0]            rd_wide;
	logic [AW-1:0]            raddr;
	logic [SAMPLE_W-1:0]      rd_data;

	assign left    = first_q + pos_q[RATIO_W-1:FRAC_W];
	assign frac    = pos_q[FRAC_W-1:0];
	assign right_n = {1'b0, left} + (IDX_W+1)'(frac != '0);
	assign right   = (right_n > {1'b0, last_c}) ? last_c : right_n[IDX_W-1:0];
	assign first_s = $signed({{(TAPP_W-IDX_W){1'b0}}, first_q});
	assign last_s  = $signed({{(TAPP_W-IDX_W){1'b0}}, last_c});
	assign tidx    = first_s + p_q;

	always_comb begin
		if (tidx < first_s) begin
			tent_idx = first_q;
		end else if (tidx > last_s) begin
			tent_idx = last_c;
		end else begin
			tent_idx = tidx[IDX_W-1:0];
		end
	end

	always_comb begin
		case (cmd.rd_src)
			RD_TAP0: rd_idx = left;
			RD_TAP1: rd_idx = right;
			RD_TENT: rd_idx = tent_idx;
			default: rd_idx = left;
		endcase
	end

	assign rd_wide = (CW'(rd_idx) > CW'(LINE_DEPTH - 1)) ? CW'(LINE_DEPTH - 1) : CW'(rd_idx);
	assign raddr   = rd_wide[AW-1:0];

	lrbt_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (LINE_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (accept && room),
		.waddr (load_cnt_q[AW-1:0]),
		.wdata (in_ch.sample_in),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// Multiply-accumulate
	logic [WGT_W-1:0]         wgt;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;

	always_comb begin
		case (cmd.wt_src)
			WT_TAP0: wgt = is_box ? WGT_ONE : WGT_ONE - {1'b0, frac};
			WT_TAP1: wgt = {1'b0, frac};
			WT_DIV:  wgt = {qhigh_q, div_quot[FRAC_W-1:0]};
			default: wgt = WGT_ONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= $signed(rd_data) * $signed({1'b0, wgt});
		end
		if (cmd.clear_acc) begin
			acc_q <= '0;
		end else if (cmd.acc) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	// Scale down with truncation toward zero, then saturate
	logic signed [ACC_W-1:0]    acc_adj;
	logic signed [VQ_W-1:0]     vq;
	logic signed [SAMPLE_W-1:0] v_sat;

	assign acc_adj = acc_q + $signed({{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{acc_q[ACC_W-1]}}});
	assign vq      = acc_adj[ACC_W-1:FRAC_W];

	always_comb begin
		if (vq > SAT_HI) begin
			v_sat = SAT_HI[SAMPLE_W-1:0];
		end else if (vq < SAT_LO) begin
			v_sat = SAT_LO[SAMPLE_W-1:0];
		end else begin
			v_sat = vq[SAMPLE_W-1:0];
		end
	end

	// Output register
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_sample_q;
	logic                out_last_q;
	logic                k_last;

	assign k_last = (k_q == den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_sample_q <= v_sat;
			out_last_q   <= k_last;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_sample_q;
	assign out_ch.out_last   = out_last_q;

	// Status
	assign st.line_done  = accept && in_ch.line_end;
	assign st.div_busy   = div_busy;
	assign st.tent       = !is_box && (diff > den_x);
	assign st.linear     = !is_box && (diff < den_x);
	assign st.w_pos      = w_pos;
	assign st.tap_last   = (j_q == span_q - SPAN_W'(1));
	assign st.total_zero = (total_q == '0);
	assign st.k_last     = k_last;
	assign st.out_free   = !out_valid_q || out_ch.ready;

endmodule

// File: rtl/core/lrbt_ctrl.sv
// Controller of the line resampler: sequences loading, divisions and taps.
// Depends on lrbt_pkg.
module lrbt_ctrl
	import lrbt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lrbt_stat_t st,
	output lrbt_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_LOAD,
		S_RATIO_GO,
		S_RATIO_WAIT,
		S_SPAN_GO,
		S_SPAN_WAIT,
		S_OUT_BEGIN,
		S_A_RD,
		S_A_MUL,
		S_A_ACC,
		S_B_RD,
		S_B_MUL,
		S_B_ACC,
		S_TENT_A,
		S_TENT_B,
		S_P1,
		S_P1_END,
		S_P2_CHK,
		S_P2_WAIT,
		S_P2_ACC,
		S_FINAL
	} state_t;

	state_t state_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			case (state_q)
				S_LOAD:       if (st.line_done) state_q <= S_RATIO_GO;
				S_RATIO_GO:   state_q <= S_RATIO_WAIT;
				S_RATIO_WAIT: if (!st.div_busy) state_q <= S_SPAN_GO;
				S_SPAN_GO:    state_q <= S_SPAN_WAIT;
				S_SPAN_WAIT:  if (!st.div_busy) state_q <= S_OUT_BEGIN;
				S_OUT_BEGIN:  state_q <= st.tent ? S_TENT_A : S_A_RD;
				S_A_RD:       state_q <= S_A_MUL;
				S_A_MUL:      state_q <= S_A_ACC;
				S_A_ACC:      state_q <= st.linear ? S_B_RD : S_FINAL;
				S_B_RD:       state_q <= S_B_MUL;
				S_B_MUL:      state_q <= S_B_ACC;
				S_B_ACC:      state_q <= S_FINAL;
				S_TENT_A:     state_q <= S_TENT_B;
				S_TENT_B:     state_q <= S_P1;
				S_P1:         if (st.tap_last) state_q <= S_P1_END;
				S_P1_END:     state_q <= st.total_zero ? S_FINAL : S_P2_CHK;
				S_P2_CHK: begin
					if (st.w_pos) begin
						state_q <= S_P2_WAIT;
					end else if (st.tap_last) begin
						state_q <= S_FINAL;
					end
				end
				S_P2_WAIT:    if (!st.div_busy) state_q <= S_P2_ACC;
				S_P2_ACC:     state_q <= st.tap_last ? S_FINAL : S_P2_CHK;
				S_FINAL: begin
					if (st.out_free) begin
						state_q <= st.k_last ? S_LOAD : S_OUT_BEGIN;
					end
				end
				default:      state_q <= S_LOAD;
			endcase
		end
	end

	// Command decode
	always_comb begin
		cmd = '0;
		cmd.div_sel = DIV_RATIO;
		cmd.rd_src  = RD_TAP0;
		cmd.wt_src  = WT_TAP0;
		case (state_q)
			S_LOAD:       cmd.load = 1'b1;
			S_RATIO_GO:   cmd.div_start = 1'b1;
			S_RATIO_WAIT: cmd.take_ratio = !st.div_busy;
			S_SPAN_GO: begin
				cmd.div_sel   = DIV_SPAN;
				cmd.div_start = 1'b1;
			end
			S_SPAN_WAIT:  cmd.take_span = !st.div_busy;
			S_OUT_BEGIN:  cmd.clear_acc = 1'b1;
			S_A_RD:       cmd.rd_en = 1'b1;
			S_A_MUL:      cmd.mul = 1'b1;
			S_A_ACC:      cmd.acc = 1'b1;
			S_B_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_TAP1;
			end
			S_B_MUL: begin
				cmd.mul    = 1'b1;
				cmd.wt_src = WT_TAP1;
			end
			S_B_ACC:      cmd.acc = 1'b1;
			S_TENT_A:     cmd.tent_a = 1'b1;
			S_TENT_B:     cmd.tent_b = 1'b1;
			S_P1: begin
				cmd.p1_step = 1'b1;
				cmd.tap_adv = 1'b1;
			end
			S_P1_END:     cmd.p2_init = !st.total_zero;
			S_P2_CHK: begin
				cmd.div_sel = DIV_WEIGHT;
				cmd.rd_src  = RD_TENT;
				if (st.w_pos) begin
					cmd.div_start = 1'b1;
					cmd.rd_en     = 1'b1;
				end else begin
					cmd.tap_adv = 1'b1;
				end
			end
			S_P2_WAIT: begin
				cmd.wt_src = WT_DIV;
				cmd.mul    = !st.div_busy;
			end
			S_P2_ACC: begin
				cmd.acc     = 1'b1;
				cmd.tap_adv = 1'b1;
			end
			S_FINAL:      cmd.emit = st.out_free;
			default:      cmd.load = 1'b0;
		endcase
	end

endmodule

// File: rtl/core/line_resampler_box_triangle.sv
// Line resampler, box and triangle filters. Samples of a line load one per
// cycle into the line store; the request marked line_end also starts the
// resampling of first_index..last_index into out_count results (clamped to
// 2..OUT_MAX), and no sample is taken until the last result of the line has
// entered the output register. Per line, two divisions (ratio and tent span,
// 24 quotient bits each) come first. Each result then reads one tap in box
// mode or when the ratio is exactly 1, two taps on the interpolating path,
// and on the tent path sums the positive span tap weights, then divides each
// positive tap weight by that total through the shared one-bit-per-cycle
// divider and the single multiply-accumulate unit. A result waiting on the
// output holds back the next one. The line store needs no clearing pass.
// Depends on lrbt_pkg, the two channel interfaces, lrbt_dp, lrbt_ctrl and the assertion header.
`include "line_resampler_box_triangle_assert.svh"

module line_resampler_box_triangle
	import lrbt_pkg::*;
#(
	parameter int LINE_DEPTH = 256,
	parameter int OUT_MAX    = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_ADDR_W-1:0] cfg_index,
	input  logic [REG_DATA_W-1:0] cfg_data,
	lrbt_in_if.sink               in_ch,
	lrbt_out_if.source            out_ch
);

	lrbt_cmd_t  cmd;
	lrbt_stat_t st;

	// Datapath
	lrbt_dp #(
		.LINE_DEPTH (LINE_DEPTH),
		.OUT_MAX    (OUT_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Controller
	lrbt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// While loading, a result still waiting can only be the last of its line
	`LRBT_ASSERT_IMPL(a_load_after_last, in_ch.ready && out_ch.valid, out_ch.out_last, "result pending mid-line while loading")
	// Divider is never restarted while working
	`LRBT_ASSERT_IMPL(a_div_idle_start, cmd.div_start, !st.div_busy, "divider started while busy")
	// An emitted result shows on the output next cycle
	`LRBT_ASSERT_NEXT(a_emit_visible, cmd.emit, out_ch.valid, "emitted result not presented")

endmodule
